// File: rtl/core/q2e_pkg.sv
package q2e_pkg;

   // Operand widths
   localparam int IN_W         = 16;
   localparam int IN_FRAC_BITS = 15;
   localparam int ARG_W        = 35;   // atan2 operands, |v| <= 2^34
   localparam int ANG_W        = 34;   // angles in Q.29 radians
   localparam int CW           = 44;   // CORDIC datapath
   localparam int NORM_W       = 41;   // magnitude word for normalization
   localparam int NORM_STEPS   = 6;    // shifts of 32,16,8,4,2,1
   localparam int RAD_W        = 64;   // square root radicand
   localparam int SQRT_STEPS   = RAD_W / 2;
   localparam int ROOT_W       = 33;
   localparam int OUT_W        = ANG_W - 15;
   localparam int ANG_OUT_W    = 16;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;

   // Lanes of the shared atan2 pipeline
   localparam int LANES      = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_YAW   = 1;
   localparam int LANE_PITCH = 2;

   localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd1686629713);
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd843314857);
   localparam logic signed [OUT_W-1:0] OUT_PI      = OUT_W'(25736);
   localparam logic signed [OUT_W-1:0] OUT_TWO_PI  = OUT_W'(51472);

   // Norm below 1e-8: s * 1e16 < 2^(2*frac)
   localparam logic [63:0] DEGEN_LIMIT_64 =
      ((64'd1 << (2 * IN_FRAC_BITS)) - 64'd1) / 64'd10000000000000000;
   localparam logic signed [ARG_W-1:0] DEGEN_LIMIT = ARG_W'(DEGEN_LIMIT_64);

   // atan(2^-i) in Q.29, rounded to nearest
   localparam logic signed [31:0] ATAN_TAB [TABLE_LEN] = '{
      32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
      32'sd33510843, 32'sd16771758, 32'sd8387925, 32'sd4194219,
      32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144,
      32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
      32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024,
      32'sd512, 32'sd256, 32'sd128, 32'sd64
   };

   // Operands carried alongside the square root
   typedef struct packed {
      logic signed [ARG_W-1:0] roll_y;
      logic signed [ARG_W-1:0] roll_x;
      logic signed [ARG_W-1:0] yaw_y;
      logic signed [ARG_W-1:0] yaw_x;
      logic signed [ARG_W-1:0] pitch_y;
      logic                    sat;     // |p| >= s, pitch is +-pi/2
      logic                    big;     // s - |p| above 32 bits
      logic                    degen;
   } side_type;

   // Q.29 to Q3.13 with round half up, then wrap to [-pi, pi)
   function automatic logic signed [ANG_OUT_W-1:0] to_out(
      input logic signed [ANG_W-1:0] ang);
      logic signed [ANG_W:0]   sum;
      logic signed [OUT_W-1:0] v;
      sum = (ANG_W+1)'(ang) + (ANG_W+1)'(32768);
      v   = sum[ANG_W:16];
      if (v >= OUT_PI) begin
         v = v - OUT_TWO_PI;
      end else if (v < -OUT_PI) begin
         v = v + OUT_TWO_PI;
      end
      return v[ANG_OUT_W-1:0];
   endfunction

endpackage

// File: rtl/core/q2e_req_if.sv
interface q2e_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [q2e_pkg::IN_W-1:0]     comp_x;
   logic signed [q2e_pkg::IN_W-1:0]     comp_y;
   logic signed [q2e_pkg::IN_W-1:0]     comp_z;
   logic signed [q2e_pkg::IN_W-1:0]     comp_w;

   modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
   modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

// File: rtl/core/q2e_rsp_if.sv
interface q2e_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [q2e_pkg::ANG_OUT_W-1:0]  roll_out;
   logic signed [q2e_pkg::ANG_OUT_W-1:0]  pitch_out;
   logic signed [q2e_pkg::ANG_OUT_W-1:0]  yaw_out;
   logic                                  degenerate;

   modport source (output valid, roll_out, pitch_out, yaw_out, degenerate, input ready);
   modport sink (input valid, roll_out, pitch_out, yaw_out, degenerate, output ready);
endinterface

// File: rtl/core/q2e_front.sv
// Products, sums, atan2 operands and the radicand: four register stages.
module q2e_front (
   input  logic                          clock,
   input  logic                          reset,
   q2e_req_if.sink                       req,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [q2e_pkg::RAD_W-1:0]     out_rad,
   output q2e_pkg::side_type             out_side
);

   localparam int AW = q2e_pkg::ARG_W;

   logic [3:0] v_ff;
   logic [3:0] v_in;
   logic [3:0] en;

   // Stage 1: products
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, wx_ff, yz_ff, wz_ff, xy_ff, wy_ff, zx_ff;
   // Stage 2: sums
   logic signed [AW-1:0] s_ff, sxy2_ff, syz2_ff, ry_ff, yw_ff, p_ff;
   logic signed [AW-1:0] s_in, sxy2_in, syz2_in, ry_in, yw_in, p_in;
   // Stage 3: operands and radicand factors
   q2e_pkg::side_type    side3_ff, side3_in;
   logic [31:0]          d_ff;
   logic [33:0]          e_ff;
   logic signed [AW-1:0] pm, dd, ee;
   // Stage 4: radicand
   q2e_pkg::side_type    side4_ff;
   logic [65:0]          prod;
   logic [q2e_pkg::RAD_W-1:0] rad_ff;

   // Handshake: a stage loads when it is empty or the next one moves
   assign en[3] = !v_ff[3] || out_ready;
   assign en[2] = !v_ff[2] || en[3];
   assign en[1] = !v_ff[1] || en[2];
   assign en[0] = !v_ff[0] || en[1];
   assign v_in  = {v_ff[2:0], req.valid};
   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // Stage 1
   always_ff @(posedge clock) begin
      if (en[0]) begin
         xx_ff <= req.comp_x * req.comp_x;
         yy_ff <= req.comp_y * req.comp_y;
         zz_ff <= req.comp_z * req.comp_z;
         ww_ff <= req.comp_w * req.comp_w;
         wx_ff <= req.comp_w * req.comp_x;
         yz_ff <= req.comp_y * req.comp_z;
         wz_ff <= req.comp_w * req.comp_z;
         xy_ff <= req.comp_x * req.comp_y;
         wy_ff <= req.comp_w * req.comp_y;
         zx_ff <= req.comp_z * req.comp_x;
      end
   end

   // Stage 2
   always_comb begin
      s_in    = AW'(xx_ff) + AW'(yy_ff) + AW'(zz_ff) + AW'(ww_ff);
      sxy2_in = (AW'(xx_ff) + AW'(yy_ff)) <<< 1;
      syz2_in = (AW'(yy_ff) + AW'(zz_ff)) <<< 1;
      ry_in   = (AW'(wx_ff) + AW'(yz_ff)) <<< 1;
      yw_in   = (AW'(wz_ff) + AW'(xy_ff)) <<< 1;
      p_in    = (AW'(wy_ff) - AW'(zx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s_ff    <= s_in;
         sxy2_ff <= sxy2_in;
         syz2_ff <= syz2_in;
         ry_ff   <= ry_in;
         yw_ff   <= yw_in;
         p_ff    <= p_in;
      end
   end

   // Stage 3: degenerate input zeroes all operands, so every angle is zero
   always_comb begin
      pm = p_ff[AW-1] ? -p_ff : p_ff;
      dd = s_ff - pm;
      ee = s_ff + pm;
      side3_in.degen = (s_ff <= q2e_pkg::DEGEN_LIMIT);
      side3_in.sat   = (pm >= s_ff);
      side3_in.big   = (dd > AW'(64'hFFFF_FFFF));
      if (side3_in.degen) begin
         side3_in.roll_y  = '0;
         side3_in.roll_x  = '0;
         side3_in.yaw_y   = '0;
         side3_in.yaw_x   = '0;
         side3_in.pitch_y = '0;
      end else begin
         side3_in.roll_y  = ry_ff;
         side3_in.roll_x  = s_ff - sxy2_ff;
         side3_in.yaw_y   = yw_ff;
         side3_in.yaw_x   = s_ff - syz2_ff;
         side3_in.pitch_y = p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side3_ff <= side3_in;
         d_ff     <= dd[31:0];
         e_ff     <= ee[33:0];
      end
   end

   // Stage 4: s^2 - p^2 as (s - |p|)(s + |p|)
   assign prod = 66'(d_ff) * 66'(e_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         side4_ff <= side3_ff;
         rad_ff   <= prod[q2e_pkg::RAD_W-1:0];
      end
   end

   assign out_valid = v_ff[3];
   assign out_rad   = rad_ff;
   assign out_side  = side4_ff;

endmodule

// File: rtl/core/q2e_isqrt.sv
// Integer square root, one result bit per register stage.
module q2e_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [q2e_pkg::RAD_W-1:0]     in_rad,
   input  q2e_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [q2e_pkg::ROOT_W-1:0]    out_root,
   output q2e_pkg::side_type             out_side
);

   localparam int NST = q2e_pkg::SQRT_STEPS;
   localparam int RW  = q2e_pkg::RAD_W;

   logic [NST-1:0]    v_ff;
   logic [NST-1:0]    v_in;
   logic [NST-1:0]    en;
   logic [RW-1:0]     rem_ff  [NST-1];
   logic [RW-1:0]     root_ff [NST];
   q2e_pkg::side_type side_ff [NST];

   // Valid chain
   assign en[NST-1] = !v_ff[NST-1] || out_ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign v_in     = {v_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // Digit stages
   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam logic [RW-1:0] BITV = RW'(1) << (RW - 2 - 2 * k);
      logic [RW-1:0]     rem_p, root_p, trial;
      logic              take;
      q2e_pkg::side_type side_p;

      if (k == 0) begin : g_first
         assign rem_p  = in_rad;
         assign root_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign trial = root_p + BITV;
      assign take  = (rem_p >= trial);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            root_ff[k] <= take ? (root_p >> 1) + BITV : root_p >> 1;
            side_ff[k] <= side_p;
         end
      end

      if (k < NST - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k] <= take ? rem_p - trial : rem_p;
            end
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_root  = root_ff[NST-1][q2e_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[NST-1];

endmodule

// File: rtl/core/q2e_atan2.sv
// Three-lane vectoring CORDIC atan2: input, normalize, half-turn, iterations.
module q2e_atan2 #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [q2e_pkg::ARG_W-1:0]     in_y [q2e_pkg::LANES],
   input  logic signed [q2e_pkg::ARG_W-1:0]     in_x [q2e_pkg::LANES],
   input  logic                                 in_degen,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [q2e_pkg::ANG_W-1:0]     out_ang [q2e_pkg::LANES],
   output logic                                 out_degen
);

   localparam int LN  = q2e_pkg::LANES;
   localparam int AW  = q2e_pkg::ARG_W;
   localparam int ZW  = q2e_pkg::ANG_W;
   localparam int CW  = q2e_pkg::CW;
   localparam int MW  = q2e_pkg::NORM_W;
   localparam int NS  = q2e_pkg::NORM_STEPS;
   localparam int ROT = NS + 1;
   localparam int NST = NS + 2 + CORDIC_STEPS;

   logic [NST-1:0]       v_ff;
   logic [NST-1:0]       v_in;
   logic [NST-1:0]       en;
   logic [NST-1:0]       dg_ff;
   logic [NST-1:0]       dg_in;
   logic signed [CW-1:0] x_ff  [NST][LN];
   logic signed [CW-1:0] y_ff  [NST][LN];
   logic signed [ZW-1:0] z_ff  [NST][LN];
   logic                 sp_ff [NST][LN];
   logic [MW-1:0]        m_ff  [NS][LN];

   // Valid chain
   assign en[NST-1] = !v_ff[NST-1] || out_ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign v_in     = {v_ff[NST-2:0], in_valid};
   assign dg_in    = {dg_ff[NST-2:0], in_degen};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            dg_ff[k] <= dg_in[k];
         end
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_stage
      if (k == 0) begin : g_in
         // Axis cases resolve here and bypass the iterations
         for (genvar l = 0; l < LN; l++) begin : g_lane
            logic [AW-1:0]        ax, ay;
            logic                 yz, xz;
            logic signed [ZW-1:0] spz;
            always_comb begin
               ax = in_x[l][AW-1] ? AW'(-in_x[l]) : AW'(in_x[l]);
               ay = in_y[l][AW-1] ? AW'(-in_y[l]) : AW'(in_y[l]);
               yz = (in_y[l] == '0);
               xz = (in_x[l] == '0);
               if (yz) begin
                  spz = in_x[l][AW-1] ? q2e_pkg::ANG_PI : '0;
               end else begin
                  spz = in_y[l][AW-1] ? -q2e_pkg::ANG_HALF_PI : q2e_pkg::ANG_HALF_PI;
               end
            end
            always_ff @(posedge clock) begin
               if (en[k]) begin
                  x_ff[k][l]  <= CW'(in_x[l]);
                  y_ff[k][l]  <= CW'(in_y[l]);
                  m_ff[k][l]  <= MW'(ax | ay);
                  sp_ff[k][l] <= yz || xz;
                  z_ff[k][l]  <= (yz || xz) ? spz : '0;
               end
            end
         end
      end else if (k <= NS) begin : g_norm
         // Leading-zero normalization, one binary shift step per stage
         localparam int B = 1 << (NS - k);
         for (genvar l = 0; l < LN; l++) begin : g_lane
            logic hit;
            assign hit = (m_ff[k-1][l][MW-1 -: B] == '0);
            always_ff @(posedge clock) begin
               if (en[k]) begin
                  x_ff[k][l]  <= hit ? x_ff[k-1][l] <<< B : x_ff[k-1][l];
                  y_ff[k][l]  <= hit ? y_ff[k-1][l] <<< B : y_ff[k-1][l];
                  z_ff[k][l]  <= z_ff[k-1][l];
                  sp_ff[k][l] <= sp_ff[k-1][l];
               end
            end
            if (k < NS) begin : g_m
               always_ff @(posedge clock) begin
                  if (en[k]) begin
                     m_ff[k][l] <= hit ? m_ff[k-1][l] << B : m_ff[k-1][l];
                  end
               end
            end
         end
      end else if (k == ROT) begin : g_rot
         // Left half-plane: rotate by pi first
         for (genvar l = 0; l < LN; l++) begin : g_lane
            logic flip;
            assign flip = !sp_ff[k-1][l] && x_ff[k-1][l][CW-1];
            always_ff @(posedge clock) begin
               if (en[k]) begin
                  x_ff[k][l]  <= flip ? -x_ff[k-1][l] : x_ff[k-1][l];
                  y_ff[k][l]  <= flip ? -y_ff[k-1][l] : y_ff[k-1][l];
                  sp_ff[k][l] <= sp_ff[k-1][l];
                  if (flip) begin
                     z_ff[k][l] <= y_ff[k-1][l][CW-1] ? -q2e_pkg::ANG_PI : q2e_pkg::ANG_PI;
                  end else begin
                     z_ff[k][l] <= z_ff[k-1][l];
                  end
               end
            end
         end
      end else begin : g_iter
         // One micro-rotation per stage
         localparam int I = k - ROT - 1;
         localparam logic signed [ZW-1:0] DA = ZW'(q2e_pkg::ATAN_TAB[I]);
         for (genvar l = 0; l < LN; l++) begin : g_lane
            logic signed [CW-1:0] xs, ys;
            assign xs = x_ff[k-1][l] >>> I;
            assign ys = y_ff[k-1][l] >>> I;
            always_ff @(posedge clock) begin
               if (en[k]) begin
                  sp_ff[k][l] <= sp_ff[k-1][l];
                  if (sp_ff[k-1][l]) begin
                     x_ff[k][l] <= x_ff[k-1][l];
                     y_ff[k][l] <= y_ff[k-1][l];
                     z_ff[k][l] <= z_ff[k-1][l];
                  end else if (!y_ff[k-1][l][CW-1]) begin
                     x_ff[k][l] <= x_ff[k-1][l] + ys;
                     y_ff[k][l] <= y_ff[k-1][l] - xs;
                     z_ff[k][l] <= z_ff[k-1][l] + DA;
                  end else begin
                     x_ff[k][l] <= x_ff[k-1][l] - ys;
                     y_ff[k][l] <= y_ff[k-1][l] + xs;
                     z_ff[k][l] <= z_ff[k-1][l] - DA;
                  end
               end
            end
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_degen = dg_ff[NST-1];
   for (genvar l = 0; l < LN; l++) begin : g_out
      assign out_ang[l] = z_ff[NST-1][l];
   end

endmodule

// File: rtl/core/quaternion_to_euler_remap.sv
// Quaternion (x, y, z, w in signed Q1.15) to remapped ZYX Euler angles in signed
// Q3.13 radians, wrapped to [-pi, pi): roll_out is the raw pitch, pitch_out the
// negated raw roll, yaw_out the yaw. Normalization is implicit: every ratio is
// formed against s = x^2+y^2+z^2+w^2. One quaternion is accepted per clock unless a
// full pipeline is stalled from the result side; each result passes through 4 stages
// of products and sums, 32 stages of square root (one root bit per stage, for the
// pitch cosine), 8 + CORDIC_STEPS stages of a three-lane CORDIC atan2, and one
// output register. Stalls from the result side hold the pipeline without loss;
// empty stages still take new input. An all-zero quaternion gives zero angles with
// degenerate set.
module quaternion_to_euler_remap #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   q2e_req_if.sink   req,
   q2e_rsp_if.source rsp
);

   localparam int LN = q2e_pkg::LANES;
   localparam int AW = q2e_pkg::ARG_W;
   localparam int ZW = q2e_pkg::ANG_W;

   // Front end to square root
   logic                         fr_valid, fr_ready;
   logic [q2e_pkg::RAD_W-1:0]    fr_rad;
   q2e_pkg::side_type            fr_side;
   // Square root to atan2
   logic                         sq_valid, sq_ready;
   logic [q2e_pkg::ROOT_W-1:0]   sq_root;
   q2e_pkg::side_type            sq_side;
   logic signed [AW-1:0]         at_y [LN];
   logic signed [AW-1:0]         at_x [LN];
   // atan2 to output
   logic                         at_valid, at_ready, at_degen;
   logic signed [ZW-1:0]         at_ang [LN];
   // Output register
   logic                         out_en;
   logic                         out_v_ff;
   logic signed [q2e_pkg::ANG_OUT_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic                         degen_ff;

   q2e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   q2e_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Pitch cosine: zero at saturation (gives +-pi/2), 2^32 past the root range
   always_comb begin
      at_y[q2e_pkg::LANE_ROLL]  = sq_side.roll_y;
      at_x[q2e_pkg::LANE_ROLL]  = sq_side.roll_x;
      at_y[q2e_pkg::LANE_YAW]   = sq_side.yaw_y;
      at_x[q2e_pkg::LANE_YAW]   = sq_side.yaw_x;
      at_y[q2e_pkg::LANE_PITCH] = sq_side.pitch_y;
      if (sq_side.sat) begin
         at_x[q2e_pkg::LANE_PITCH] = '0;
      end else if (sq_side.big) begin
         at_x[q2e_pkg::LANE_PITCH] = AW'(64'h1_0000_0000);
      end else begin
         at_x[q2e_pkg::LANE_PITCH] = AW'(sq_root);
      end
   end

   q2e_atan2 #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_atan2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_y      (at_y),
      .in_x      (at_x),
      .in_degen  (sq_side.degen),
      .out_valid (at_valid),
      .out_ready (at_ready),
      .out_ang   (at_ang),
      .out_degen (at_degen)
   );

   // Output register: remap, round to Q3.13, wrap
   assign out_en   = !out_v_ff || rsp.ready;
   assign at_ready = out_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= at_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         roll_ff  <= q2e_pkg::to_out(at_ang[q2e_pkg::LANE_PITCH]);
         pitch_ff <= q2e_pkg::to_out(-at_ang[q2e_pkg::LANE_ROLL]);
         yaw_ff   <= q2e_pkg::to_out(at_ang[q2e_pkg::LANE_YAW]);
         degen_ff <= at_degen;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.roll_out   = roll_ff;
   assign rsp.pitch_out  = pitch_ff;
   assign rsp.yaw_out    = yaw_ff;
   assign rsp.degenerate = degen_ff;

`ifndef SYNTH
   // An empty output register opens the whole pipeline to new input
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with no result pending");

   // Degenerate results carry zero angles
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |->
         rsp.roll_out == '0 && rsp.pitch_out == '0 && rsp.yaw_out == '0)
      else $error("degenerate result with nonzero angle");

   // Every angle lies in [-pi, pi)
   a_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |->
         rsp.roll_out >= -16'sd25736 && rsp.roll_out <= 16'sd25735 &&
         rsp.pitch_out >= -16'sd25736 && rsp.pitch_out <= 16'sd25735 &&
         rsp.yaw_out >= -16'sd25736 && rsp.yaw_out <= 16'sd25735)
      else $error("angle outside wrap range");
`endif

endmodule

// File: test/tb_quaternion_to_euler_remap.sv
module tb_quaternion_to_euler_remap;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        LATENCY    = 45 + q2e_pkg::CORDIC_STEPS_DEF;
   localparam longint    NORM_FLOOR = 64'sd1 << 40;
   localparam longint    PI_Q29     = 1686629713;
   localparam longint    HPI_Q29    = 843314857;
   localparam int        PI_Q13     = 25736;

   typedef struct {
      logic signed [q2e_pkg::ANG_OUT_W-1:0] roll;
      logic signed [q2e_pkg::ANG_OUT_W-1:0] pitch;
      logic signed [q2e_pkg::ANG_OUT_W-1:0] yaw;
      logic                                 degen;
   } angles_type;

   logic clock;
   logic reset;

   q2e_req_if req_ch ();
   q2e_rsp_if rsp_ch ();

   quaternion_to_euler_remap dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   angles_type angle_queue[$];
   int         mismatches;
   int         burst_left;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard time limit
   initial begin
      #20ms;
      $display("** quaternion_to_euler_remap: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Vectoring CORDIC, angle in Q.29
   function automatic longint cordic_atan2(longint y, longint x);
      longint ang;
      longint xs;
      longint ys;
      ang = 0;
      if (y == 0) return x < 0 ? PI_Q29 : 0;
      if (x == 0) return y > 0 ? HPI_Q29 : -HPI_Q29;
      while (abs64(x) < NORM_FLOOR && abs64(y) < NORM_FLOOR) begin
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         ang = (y >= 0) ? PI_Q29 : -PI_Q29;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < q2e_pkg::CORDIC_STEPS_DEF && i < q2e_pkg::TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + longint'(q2e_pkg::ATAN_TAB[i]);
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - longint'(q2e_pkg::ATAN_TAB[i]);
         end
      end
      return ang;
   endfunction

   // Q.29 to Q3.13, round half up, wrap to [-pi, pi)
   function automatic logic signed [q2e_pkg::ANG_OUT_W-1:0] q29_to_q13(longint ang);
      longint v;
      v = (ang + 32768) >>> 16;
      if (v >= PI_Q13) v = v - 2 * PI_Q13;
      else if (v < -PI_Q13) v = v + 2 * PI_Q13;
      return v[q2e_pkg::ANG_OUT_W-1:0];
   endfunction

   function automatic angles_type predict_angles(logic signed [q2e_pkg::IN_W-1:0] qx,
      logic signed [q2e_pkg::IN_W-1:0] qy, logic signed [q2e_pkg::IN_W-1:0] qz,
      logic signed [q2e_pkg::IN_W-1:0] qw);
      angles_type      a;
      longint          x, y, z, w, s, p, roll, yaw, pitch;
      longint unsigned d, e, c;
      x = qx; y = qy; z = qz; w = qw;
      s = x * x + y * y + z * z + w * w;
      if (s <= longint'(q2e_pkg::DEGEN_LIMIT_64)) begin
         a.roll = '0; a.pitch = '0; a.yaw = '0; a.degen = 1'b1;
         return a;
      end
      roll = cordic_atan2(2 * (w * x + y * z), s - 2 * (x * x + y * y));
      yaw  = cordic_atan2(2 * (w * z + x * y), s - 2 * (y * y + z * z));
      p = 2 * (w * y - z * x);
      if (abs64(p) >= longint'(s)) begin
         pitch = p > 0 ? HPI_Q29 : -HPI_Q29;
      end else begin
         d = longint'(s) - abs64(p);
         e = longint'(s) + abs64(p);
         c = (d > 64'hFFFF_FFFF) ? (64'd1 << 32) : int_sqrt(d * e);
         pitch = cordic_atan2(p, longint'(c));
      end
      a.roll  = q29_to_q13(pitch);
      a.pitch = q29_to_q13(-roll);
      a.yaw   = q29_to_q13(yaw);
      a.degen = 1'b0;
      return a;
   endfunction

   // ------------------------------------------------------------- result check
   always @(posedge clock) begin
      angles_type exp_a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (angle_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer at %0t", $realtime);
         end else begin
            exp_a = angle_queue.pop_front();
            if (rsp_ch.roll_out !== exp_a.roll || rsp_ch.pitch_out !== exp_a.pitch ||
                rsp_ch.yaw_out !== exp_a.yaw || rsp_ch.degenerate !== exp_a.degen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp r/p/y/d %0d %0d %0d %0b got %0d %0d %0d %0b",
                     $realtime, exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.degen,
                     rsp_ch.roll_out, rsp_ch.pitch_out, rsp_ch.yaw_out,
                     rsp_ch.degenerate);
            end
         end
      end
   end

   // Receiver stalls: mode changes whenever a random countdown runs out
   int          stall_mode;
   int          stall_cnt;
   logic [7:0]  stall_pat;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cnt    <= 0;
      end else begin
         if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_pat  <= $urandom;
            stall_cnt  <= $urandom_range(50, 400);
         end else begin
            stall_cnt <= stall_cnt - 1;
         end
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 99) < 70);
            2: rsp_ch.ready <= stall_pat[stall_cnt % 8];
            default: rsp_ch.ready <= ($urandom_range(0, 99) < 20);
         endcase
      end
   end

   // ------------------------------------------------------------------ sender
   task automatic send_quat(logic signed [q2e_pkg::IN_W-1:0] qx,
      logic signed [q2e_pkg::IN_W-1:0] qy, logic signed [q2e_pkg::IN_W-1:0] qz,
      logic signed [q2e_pkg::IN_W-1:0] qw);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.comp_x <= qx;
      req_ch.comp_y <= qy;
      req_ch.comp_z <= qz;
      req_ch.comp_w <= qw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      angle_queue.push_back(predict_angles(qx, qy, qz, qw));
   endtask

   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (angle_queue.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------- tests
   task automatic test_special_cases();
      send_quat(0, 0, 0, 0);                 // zero quaternion
      send_quat(0, 0, 0, 32767);             // identity
      send_quat(0, 0, 0, -32768);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(32767, 0, 0, 0);             // roll of pi
      send_quat(-32768, 0, 0, 0);
      send_quat(0, 32767, 0, 0);
      send_quat(0, 0, 32767, 0);             // yaw of pi
      send_quat(0, 0, -32768, 0);
      send_quat(0, 23170, 0, 23170);         // pitch saturation, positive
      send_quat(0, -23170, 0, 23170);        // negative
      send_quat(16384, 16384, 16384, 16384); // equal components, pitch of zero
      send_quat(-16384, 16384, 16384, -16384);
      send_quat(1, 0, 0, 0);                 // smallest nonzero
      send_quat(0, 0, 0, -1);
      send_quat(0, 1, 0, 1);
      send_quat(23170, 0, 0, 23170);
      send_quat(0, 0, 23170, -23170);
   endtask

   task automatic test_random_full(int n);
      for (int i = 0; i < n; i++)
         send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_random_small(int n);
      for (int i = 0; i < n; i++)
         send_quat(16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8),
                   16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8));
   endtask

   // Close to pitch saturation: w ~ y, x ~ -z
   task automatic test_near_gimbal(int n);
      logic signed [q2e_pkg::IN_W-1:0] a, b;
      for (int i = 0; i < n; i++) begin
         a = 16'($urandom_range(0, 32767) - 16384);
         b = 16'($urandom_range(0, 32767) - 16384);
         send_quat(16'(b + $urandom_range(0, 6) - 3), a, -b,
                   16'(a + $urandom_range(0, 6) - 3));
      end
   endtask

   // Single-axis rotations, exercises exact axes and the wrap
   task automatic test_axes(int n);
      logic signed [q2e_pkg::IN_W-1:0] c, w;
      int                              k;
      for (int i = 0; i < n; i++) begin
         c = 16'($urandom);
         w = 16'($urandom);
         k = $urandom_range(0, 2);
         case (k)
            0: send_quat(c, 0, 0, w);
            1: send_quat(0, c, 0, w);
            default: send_quat(0, 0, c, w);
         endcase
      end
   endtask

   initial begin
      int wait_cnt;
      mismatches     = 0;
      burst_left     = 0;
      reset          = 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.comp_x  <= '0;
      req_ch.comp_y  <= '0;
      req_ch.comp_z  <= '0;
      req_ch.comp_w  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      drain_pipe();
      test_random_full(900);
      test_axes(300);
      drain_pipe();
      test_near_gimbal(400);
      test_random_small(230);

      req_ch.valid <= 1'b0;
      wait_cnt = 0;
      while (angle_queue.size() != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && angle_queue.size() == 0) begin
         $display("** quaternion_to_euler_remap: PASSED **");
      end else begin
         $display("** quaternion_to_euler_remap: FAILED **");
      end
      $finish;
   end

endmodule
